// ===== design/tfad_pkg.sv =====
package tfad_pkg;

  // Averaging weights in Q16: 0.01 toward the new sample, the rest kept.
  localparam logic [9:0]  ALPHA_Q16      = 10'd655;
  localparam logic [15:0] KEEP_Q16       = 16'd64881;

  // Decay factor: upper bound 0.99 minus a level-dependent drop.
  // The drop stays below 64, so the factor never reaches the 0.70 floor.
  localparam logic [15:0] FACTOR_HI_Q16  = 16'd64880;
  localparam logic [14:0] FACTOR_SPAN    = 15'd19005;

  localparam logic [46:0] ROUND_BIAS     = 47'd32768;

  // floor(y / 150) = (y * RECIP_150) >> 32, exact for any 24-bit y.
  localparam logic [24:0] RECIP_150      = 25'd28633116;

  localparam logic [15:0] OUT_MAX        = 16'hFFFF;

  // Register indexes on the configuration port.
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_INTERVAL  = 1'b1;

  // Operand selection for the shared multiplier.
  typedef enum logic [2:0] {
    MUL_AVG    = 3'd0,
    MUL_DROP   = 3'd1,
    MUL_FACTOR = 3'd2,
    MUL_ASSIST = 3'd3,
    MUL_RECIP  = 3'd4
  } mul_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    in_ready;
    logic    load_in;
    logic    mul_en;
    mul_op_t mul_op;
    logic    upd_avg;
    logic    upd_decay;
    logic    load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic take_avg;
    logic take_decay;
    logic out_stall;
  } stat_t;

endpackage

// ===== design/torque_filter_adaptive_decay.sv =====
// Each accepted word takes its filter update (none, averaging or a decay
// step), then output scaling and division by 150; the next word is taken only
// once the result is loaded into the output register. One shared multiplier
// carries the filter and output-scaling products, apart from the averaging
// gain. A result left waiting holds the next word in its last step.
// Reset (synchronous, rst_n low) clears the filter state and restores defaults.
module torque_filter_adaptive_decay (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [14:0] in_raw_torque,
  input  logic [8:0]  in_assist_level,
  input  logic [31:0] in_time_now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_motor_level,
  output logic        out_decay_applied
);
  import tfad_pkg::*;

  cmd_t        cmd;
  stat_t       stat;
  logic [14:0] torque_threshold;
  logic [15:0] decay_period;

  assign in_ready = cmd.in_ready;

  tfad_regs u_regs (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .torque_threshold (torque_threshold),
    .decay_period     (decay_period)
  );

  tfad_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  tfad_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .torque_threshold  (torque_threshold),
    .decay_period      (decay_period),
    .in_raw_torque     (in_raw_torque),
    .in_assist_level   (in_assist_level),
    .in_time_now       (in_time_now),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_motor_level   (out_motor_level),
    .out_decay_applied (out_decay_applied)
  );

endmodule

// ===== design/tfad_regs.sv =====
module tfad_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [14:0] torque_threshold,
  output logic [15:0] decay_period
);
  import tfad_pkg::*;

  logic [14:0] threshold_r;
  logic [15:0] interval_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= 15'd100;
      interval_r  <= 16'd5;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_THRESHOLD: threshold_r <= pwdata[14:0];
        REG_INTERVAL:  interval_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD: prdata = {17'd0, threshold_r};
      REG_INTERVAL:  prdata = {16'd0, interval_r};
      default:       prdata = 32'd0;
    endcase
  end

  assign torque_threshold = threshold_r;
  assign decay_period     = interval_r;

endmodule

// ===== design/tfad_ctrl.sv =====
module tfad_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  tfad_pkg::stat_t stat,
  output tfad_pkg::cmd_t  cmd
);
  import tfad_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_PROD       = 8'b0000_0010,
    S_AVG        = 8'b0000_0100,
    S_DECAY_MUL  = 8'b0000_1000,
    S_DECAY_UPD  = 8'b0001_0000,
    S_SCALE      = 8'b0010_0000,
    S_RECIP      = 8'b0100_0000,
    S_OUT        = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.mul_op    = MUL_AVG;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_PROD;
        end
      end
      S_PROD: begin
        cmd.mul_en = 1'b1;
        if (stat.take_avg) begin
          cmd.mul_op = MUL_AVG;
          state_nxt  = S_AVG;
        end else if (stat.take_decay) begin
          cmd.mul_op = MUL_DROP;
          state_nxt  = S_DECAY_MUL;
        end else begin
          // The filtered value stays as it is: go straight to scaling.
          cmd.mul_op = MUL_ASSIST;
          state_nxt  = S_RECIP;
        end
      end
      S_AVG: begin
        cmd.upd_avg = 1'b1;
        state_nxt   = S_SCALE;
      end
      S_DECAY_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_FACTOR;
        state_nxt  = S_DECAY_UPD;
      end
      S_DECAY_UPD: begin
        cmd.upd_decay = 1'b1;
        state_nxt     = S_SCALE;
      end
      S_SCALE: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_ASSIST;
        state_nxt  = S_RECIP;
      end
      S_RECIP: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_RECIP;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!stat.out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== design/tfad_dp.sv =====
module tfad_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  tfad_pkg::cmd_t  cmd,
  output tfad_pkg::stat_t stat,
  input  logic [14:0]     torque_threshold,
  input  logic [15:0]     decay_period,
  input  logic [14:0]     in_raw_torque,
  input  logic [8:0]      in_assist_level,
  input  logic [31:0]     in_time_now,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [15:0]     out_motor_level,
  output logic            out_decay_applied
);
  import tfad_pkg::*;

  logic [14:0] raw_r;
  logic [8:0]  assist_r;
  logic [31:0] now_r;
  logic [30:0] filt_r;
  logic [31:0] last_r;
  logic [55:0] prod_r;
  logic        decay_r;
  logic        out_valid_r;
  logic [15:0] out_level_r;
  logic        out_decay_r;

  logic [30:0] mul_a;
  logic [24:0] mul_b;
  logic [55:0] mul_p;
  logic [15:0] factor;
  logic [31:0] elapsed;
  logic [24:0] raw_alpha;
  logic [47:0] avg_sum;
  logic [46:0] decay_sum;
  logic [16:0] quot;
  logic [15:0] level;

  // Branch decision on the captured word.
  assign elapsed         = now_r - last_r;
  assign stat.take_avg   = raw_r >= torque_threshold;
  assign stat.take_decay = elapsed >= {16'd0, decay_period};
  assign stat.out_stall  = out_valid_r && !out_ready;

  // Decay factor from the level-dependent drop held in the product register.
  assign factor = FACTOR_HI_Q16 - {10'd0, prod_r[45:40]};

  // Shared multiplier operand selection.
  always_comb begin
    case (cmd.mul_op)
      MUL_AVG: begin
        mul_a = filt_r;
        mul_b = {9'd0, KEEP_Q16};
      end
      MUL_DROP: begin
        mul_a = filt_r;
        mul_b = {10'd0, FACTOR_SPAN};
      end
      MUL_FACTOR: begin
        mul_a = filt_r;
        mul_b = {9'd0, factor};
      end
      MUL_ASSIST: begin
        mul_a = filt_r;
        mul_b = {16'd0, assist_r};
      end
      MUL_RECIP: begin
        mul_a = {7'd0, prod_r[39:16]};
        mul_b = RECIP_150;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = {25'd0, mul_a} * {31'd0, mul_b};

  // Filter updates, rounded in Q16 and kept to 31 bits.
  assign raw_alpha = {10'd0, raw_r} * {15'd0, ALPHA_Q16};
  assign avg_sum   = {1'b0, prod_r[46:0]} + {7'd0, raw_alpha, 16'd0}
                   + {1'b0, ROUND_BIAS};
  assign decay_sum = prod_r[46:0] + ROUND_BIAS;

  // Quotient of the scaled level by 150, saturated to the output width.
  assign quot  = prod_r[48:32];
  assign level = quot[16] ? OUT_MAX : quot[15:0];

  // Captured input word and arithmetic registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      raw_r    <= in_raw_torque;
      assist_r <= in_assist_level;
      now_r    <= in_time_now;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_p;
    end
    if (cmd.load_out) begin
      out_level_r <= level;
      out_decay_r <= decay_r;
    end
  end

  // Filter state and decay bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r  <= '0;
      last_r  <= '0;
      decay_r <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        decay_r <= 1'b0;
      end
      if (cmd.upd_avg) begin
        filt_r <= avg_sum[46:16];
      end
      if (cmd.upd_decay) begin
        filt_r  <= decay_sum[46:16];
        last_r  <= now_r;
        decay_r <= 1'b1;
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_motor_level   = out_level_r;
  assign out_decay_applied = out_decay_r;

endmodule

// ===== sim/tb_torque_filter_adaptive_decay.sv =====
`timescale 1ns / 1ps

module tb_torque_filter_adaptive_decay;
  import tfad_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_WORDS   = 250;

  // Filter constants in Q16, then the output scale divisor and level limit.
  localparam logic [63:0] AVG_GAIN     = 64'd655;
  localparam logic [63:0] AVG_KEEP     = 64'd64881;
  localparam logic [63:0] DECAY_CEIL   = 64'd64880;
  localparam logic [63:0] DECAY_FLOOR  = 64'd45875;
  localparam logic [63:0] DECAY_SLOPE  = 64'd19005;
  localparam logic [63:0] HALF_LSB     = 64'd32768;
  localparam logic [63:0] ASSIST_SCALE = 64'd150;
  localparam logic [63:0] LEVEL_MAX    = 64'd65535;

  typedef struct packed {
    logic [15:0] level;
    logic        decay;
  } motor_word_t;

  // Kinds of stimulus runs: pushing above the threshold, easing off below it, or noise.
  typedef enum logic [1:0] {
    RUN_PUSH,
    RUN_EASE,
    RUN_NOISE
  } run_kind_t;

  // Tracks the filter state and the motor words still owed by the block.
  class torque_filter_predictor;
    logic [14:0]  threshold;
    logic [15:0]  interval;
    logic [30:0]  filtered;
    logic [31:0]  last_decay_tick;
    motor_word_t  expected_words[$];
    int unsigned  error_count;

    function new();
      threshold       = 15'd100;
      interval        = 16'd5;
      filtered        = '0;
      last_decay_tick = '0;
      error_count     = 0;
    endfunction

    function void set_register(logic idx, logic [31:0] value);
      case (idx)
        REG_THRESHOLD: threshold = value[14:0];
        REG_INTERVAL:  interval  = value[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // Advances the filter by one sample and queues the motor word it produces.
    function void note_sample(logic [14:0] raw, logic [8:0] assist, logic [31:0] now);
      logic [63:0] acc;
      logic [63:0] drop;
      logic [63:0] factor;
      logic [63:0] scaled;
      logic [31:0] elapsed;
      motor_word_t word;
      word.decay = 1'b0;
      acc        = {33'd0, filtered};
      elapsed    = now - last_decay_tick;
      if (raw >= threshold) begin
        acc = (({49'd0, raw} << 16) * AVG_GAIN + acc * AVG_KEEP + HALF_LSB) >> 16;
      end else if (elapsed >= {16'd0, interval}) begin
        // The factor shrinks as the filtered level grows.
        drop   = (DECAY_SLOPE * acc) >> 40;
        factor = (drop >= DECAY_CEIL) ? 64'd0 : DECAY_CEIL - drop;
        if (factor > DECAY_CEIL) factor = DECAY_CEIL;
        if (factor < DECAY_FLOOR) factor = DECAY_FLOOR;
        acc             = (acc * factor + HALF_LSB) >> 16;
        last_decay_tick = now;
        word.decay      = 1'b1;
      end
      filtered   = acc[30:0];
      scaled     = (({33'd0, filtered} * {55'd0, assist}) / ASSIST_SCALE) >> 16;
      word.level = (scaled > LEVEL_MAX) ? 16'hFFFF : scaled[15:0];
      expected_words.push_back(word);
    endfunction

    task report_mismatch(string what);
      $display("%0t ns: motor word mismatch: %s", $time, what);
      error_count++;
    endtask

    task check_output(logic [15:0] level, logic decay);
      motor_word_t want;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word level=%0d decay=%0b", level, decay));
        return;
      end
      want = expected_words.pop_front();
      if (level !== want.level) begin
        report_mismatch($sformatf("motor_level got %0d expected %0d", level, want.level));
      end
      if (decay !== want.decay) begin
        report_mismatch($sformatf("decay_applied got %0b expected %0b", decay, want.decay));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n           = 1'b0;
  logic        psel            = 1'b0;
  logic        penable         = 1'b0;
  logic        pwrite          = 1'b0;
  logic [2:0]  paddr           = '0;
  logic [31:0] pwdata          = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic [14:0] in_raw_torque   = '0;
  logic [8:0]  in_assist_level = '0;
  logic [31:0] in_time_now     = '0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic [15:0] out_motor_level;
  logic        out_decay_applied;

  torque_filter_predictor sb = new();

  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  logic        hold_request       = 1'b0;
  logic [31:0] tick_now           = 32'hFFFF_F000;
  int unsigned cycle_count        = 0;

  torque_filter_adaptive_decay DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_raw_torque     (in_raw_torque),
    .in_assist_level   (in_assist_level),
    .in_time_now       (in_time_now),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_motor_level   (out_motor_level),
    .out_decay_applied (out_decay_applied)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Accepted sample words feed the predictor; accepted motor words are checked.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.note_sample(in_raw_torque, in_assist_level, in_time_now);
    end
    if (rst_n && out_valid && out_ready) begin
      sb.check_output(out_motor_level, out_decay_applied);
    end
  end

  // Result side: random stalls, plus one long hold-off when requested.
  initial begin : receiver
    int unsigned stretch;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        stretch = 0;
        while (stretch < HOLD_CYCLES) begin
          @(posedge clk);
          stretch++;
        end
        hold_request = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
      end
    end
  end

  // Offers one sample word and waits until the block takes it.
  task automatic send_sample(input logic [14:0] raw, input logic [8:0] assist,
                             input logic [31:0] now);
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_raw_torque   <= raw;
    in_assist_level <= assist;
    in_time_now     <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops offering words and waits until every motor word has come back.
  // The first edge lets the monitor log the word accepted at the last edge.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup phase, then access phase, then the bus goes idle.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [14:0] thr, input logic [15:0] intv);
    write_reg(REG_THRESHOLD, {17'd0, thr});
    write_reg(REG_INTERVAL, {16'd0, intv});
  endtask

  // Hand-picked words: field extremes, the threshold and interval boundaries,
  // a tick counter that wraps or runs backward, zero interval and zero threshold.
  task automatic run_directed();
    send_sample(15'd0,     9'd0,   32'd0);
    send_sample(15'd32767, 9'd511, 32'd3);
    send_sample(15'd100,   9'd300, 32'd4);
    send_sample(15'd99,    9'd300, 32'd5);
    send_sample(15'd99,    9'd150, 32'd9);
    send_sample(15'd0,     9'd300, 32'd10);
    send_sample(15'd50,    9'd256, 32'd2);
    send_sample(15'd50,    9'd511, 32'hFFFF_FFFF);
    send_sample(15'd50,    9'd1,   32'd3);
    send_sample(15'd50,    9'd300, 32'd4);
    send_sample(15'd32767, 9'd511, 32'd5);
    send_sample(15'd32767, 9'd0,   32'd6);
    settle();
    write_reg(REG_INTERVAL, 32'd0);
    send_sample(15'd10, 9'd300, 32'd6);
    send_sample(15'd10, 9'd300, 32'd6);
    send_sample(15'd20, 9'd301, 32'd6);
    settle();
    write_reg(REG_THRESHOLD, 32'd0);
    send_sample(15'd0, 9'd300, 32'd7);
    send_sample(15'd0, 9'd511, 32'd8);
    settle();
    apply_setting(15'd32767, 16'd65535);
    send_sample(15'd32766, 9'd300, 32'd9);
    send_sample(15'd32767, 9'd300, 32'd10);
    send_sample(15'd0,     9'd300, 32'd65541);
    send_sample(15'd0,     9'd300, 32'd131075);
    settle();
  endtask

  // Random words in runs: long pushes above the threshold drive the filter up
  // toward saturation, easing runs exercise the decay timing, noise mixes in.
  task automatic run_random(input int unsigned count);
    run_kind_t   kind;
    int unsigned run_left;
    int unsigned span;
    int unsigned pick;
    logic [14:0] raw;
    logic [8:0]  assist;
    run_left = 0;
    kind     = RUN_NOISE;
    for (int unsigned n = 0; n < count; n++) begin
      if (run_left == 0) begin
        pick = $urandom_range(99, 0);
        if (pick < 45) begin
          kind     = RUN_PUSH;
          run_left = $urandom_range(300, 1);
        end else if (pick < 90) begin
          kind     = RUN_EASE;
          run_left = $urandom_range(60, 1);
        end else begin
          kind     = RUN_NOISE;
          run_left = $urandom_range(20, 1);
        end
      end
      run_left--;

      case (kind)
        RUN_PUSH: begin
          if (sb.threshold <= 15'd24000 && $urandom_range(1, 0) == 1) begin
            raw = 15'($urandom_range(32767, 24000));
          end else begin
            raw = 15'($urandom_range(32767, sb.threshold));
          end
        end
        RUN_EASE: begin
          if (sb.threshold == 15'd0) raw = 15'($urandom_range(32767, 0));
          else raw = 15'($urandom_range(sb.threshold - 1, 0));
        end
        default: raw = 15'($urandom_range(32767, 0));
      endcase

      if ($urandom_range(99, 0) < 15) assist = 9'($urandom_range(511, 0));
      else assist = 9'($urandom_range(300, 0));

      // The tick mostly moves forward around the decay interval, now and then
      // it jumps anywhere or steps backward.
      pick = $urandom_range(99, 0);
      if (pick < 3) begin
        tick_now = $urandom();
      end else if (pick < 5) begin
        tick_now = tick_now - $urandom_range(1000, 1);
      end else begin
        span     = 2 * sb.interval + 2;
        tick_now = tick_now + $urandom_range(span, 0);
      end

      send_sample(raw, assist, tick_now);
    end
  endtask

  // Main sequence.
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: apply_setting(15'd0, 16'd0);
        1: apply_setting(15'd32767, 16'd0);
        2: apply_setting(15'd16384, 16'd1);
        3: apply_setting(15'd2000, 16'd65535);
        4: apply_setting(15'($urandom_range(32767, 0)), 16'($urandom_range(300, 0)));
        5: apply_setting(15'd100, 16'd5);
        6: apply_setting(15'($urandom_range(32767, 0)), 16'($urandom_range(65535, 0)));
        default: apply_setting(15'd30000, 16'd40);
      endcase

      case (phase % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 57;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 57;
        end
        default: begin
          sender_idle_pct    = 29;
          receiver_stall_pct = 29;
        end
      endcase

      // One long hold-off on the result side so the block backs up its input.
      if (phase == 2) hold_request = 1'b1;

      run_random(PHASE_WORDS);
      settle();
    end

    if (sb.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
